@@ hw/rtl/fmt_pkg.sv @@
// Shared types and constants for the format markup tokenizer.
// Holds the character classes, the queued item and the result record layout.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fmt_pkg;

  // Longest string accepted; a byte at this offset or beyond is an error.
  localparam int unsigned MAX_LEN = 65535;

  // Offsets are reported in 16 bits.
  localparam int unsigned POS_W = 16;

  // Queue between the classifier and the tokenizer.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // Character codes that steer the parser.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BANG   = 8'h21;

  // Error codes carried in the result record.
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_CLOSE  = 3'd1;
  localparam logic [2:0] ERR_OPEN   = 3'd2;
  localparam logic [2:0] ERR_NOCONV = 3'd3;
  localparam logic [2:0] ERR_COLON  = 3'd4;
  localparam logic [2:0] ERR_SPEC   = 3'd5;
  localparam logic [2:0] ERR_NAME   = 3'd6;
  localparam logic [2:0] ERR_LONG   = 3'd7;

  // Class of one input byte, worked out by the front end.
  typedef enum logic [2:0] {
    CL_OTHER,
    CL_OPEN,
    CL_CLOSE,
    CL_LBRK,
    CL_RBRK,
    CL_COLON,
    CL_BANG
  } cls_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
  } item_t;

  // One result record.
  typedef struct packed {
    logic [POS_W-1:0] literal_begin;
    logic [POS_W-1:0] literal_end;
    logic             field_present;
    logic [POS_W-1:0] name_begin;
    logic [POS_W-1:0] name_end;
    logic [7:0]       conversion;
    logic [POS_W-1:0] spec_begin;
    logic [POS_W-1:0] spec_end;
    logic             spec_nested;
    logic [2:0]       error;
    logic             end_of_string;
  } record_t;

  // Sort a byte into the class the parser reacts to.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = CL_OTHER;
    if (c == CH_LBRACE) k = CL_OPEN;
    else if (c == CH_RBRACE) k = CL_CLOSE;
    else if (c == CH_LBRACK || c == CH_LPAREN) k = CL_LBRK;
    else if (c == CH_RBRACK || c == CH_RPAREN) k = CL_RBRK;
    else if (c == CH_COLON) k = CL_COLON;
    else if (c == CH_BANG) k = CL_BANG;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fmt_front.sv @@
// Front end of the format markup tokenizer: accepts bytes and classifies them.
// Writes classified items into the queue; depends on fmt_pkg.
`default_nettype none

module fmt_front (
  input  logic          byte_valid,
  output logic          byte_stall,
  input  logic [7:0]    byte_req,
  input  logic          last,
  input  logic          q_full,
  output logic          push,
  output fmt_pkg::item_t wr_item
);
  import fmt_pkg::*;

  // Hold the sender off while the queue has no room.
  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;

  // Classify the byte on its way into the queue.
  always_comb begin
    wr_item.ch   = byte_req;
    wr_item.last = last;
    wr_item.cls  = classify(byte_req);
  end

endmodule

`default_nettype wire

@@ hw/rtl/fmt_fifo.sv @@
// Short queue between the classifier and the tokenizer.
// Register based, first in first out; depends on fmt_pkg for depth and item type.
`default_nettype none

module fmt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fmt_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output fmt_pkg::item_t head_item
);
  import fmt_pkg::*;

  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);
  localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QFULL);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QLAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QLAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // The queue never holds more than its depth and is never drained when empty.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= QFULL)
    else $error("queue fill count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |=> count == $past(count) + {{(QCNT_W-1){1'b0}}, $past(push)})
    else $error("queue drained while empty");

endmodule

`default_nettype wire

@@ hw/rtl/fmt_back.sv @@
// Back end of the format markup tokenizer: the parsing state machine and the
// output record register. Takes classified items from the queue; depends on fmt_pkg.
`default_nettype none

module fmt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  fmt_pkg::item_t   head_item,
  output logic             pop,
  output logic             rec_valid,
  input  logic             rec_stall,
  output fmt_pkg::record_t rec
);
  import fmt_pkg::*;

  typedef enum logic [2:0] {
    PH_LIT,
    PH_OPEN,
    PH_CLOSE,
    PH_NAME,
    PH_CONV,
    PH_CONVX,
    PH_SPEC
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   lit_start;
    logic [POS_W-1:0]   lit_stop;
    logic [POS_W-1:0]   fname_start;
    logic [POS_W-1:0]   name_stop;
    logic [7:0]         conv_char;
    logic [POS_W-1:0]   fspec_start;
    logic               nested_seen;
    logic signed [16:0] bracket_depth;
    logic [16:0]        brace_depth;
    logic               drop_rest;
  } st_t;

  localparam st_t ST_INIT = '0;

  st_t                st;
  st_t                st_next;
  record_t            rec_next;
  logic               fire;
  logic               take;
  logic               fail_en;
  logic [2:0]         fail_code;
  logic               field_en;
  logic               field_spec;
  logic               lit_en;
  logic [POS_W-1:0]   lit_le;
  logic               spec_en;
  logic [POS_W-1:0]   p;
  logic [POS_W-1:0]   p1;
  logic               lst;
  cls_t               cls;
  logic signed [16:0] depth_n;

  // An item is processed whenever the output register is free or being emptied.
  assign take = head_valid && (!rec_valid || !rec_stall);
  assign pop  = take;

  assign p   = st.position;
  assign p1  = st.position + 1'b1;
  assign lst = head_item.last;
  assign cls = head_item.cls;

  // Parsing step for one byte.
  always_comb begin
    st_next    = st;
    rec_next   = '0;
    fire       = 1'b0;
    fail_en    = 1'b0;
    fail_code  = ERR_NONE;
    field_en   = 1'b0;
    field_spec = 1'b0;
    lit_en     = 1'b0;
    lit_le     = '0;
    spec_en    = 1'b0;
    depth_n    = st.bracket_depth;

    if (take) begin
      if (st.drop_rest) begin
        // Skip the remainder of a string that already failed.
        if (lst) st_next = ST_INIT;
      end else if (32'(p) >= MAX_LEN) begin
        fail_en   = 1'b1;
        fail_code = ERR_LONG;
      end else begin
        st_next.position = p1;
        unique case (st.phase) inside
          PH_LIT: begin
            if (cls == CL_OPEN || cls == CL_CLOSE) begin
              if (lst) begin
                fail_en   = 1'b1;
                fail_code = (cls == CL_OPEN) ? ERR_OPEN : ERR_CLOSE;
              end else begin
                st_next.lit_stop = p;
                st_next.phase    = (cls == CL_OPEN) ? PH_OPEN : PH_CLOSE;
              end
            end else if (lst) begin
              lit_en = 1'b1;
              lit_le = p1;
            end
          end
          PH_CLOSE: begin
            if (cls != CL_CLOSE) begin
              fail_en   = 1'b1;
              fail_code = ERR_CLOSE;
            end else begin
              lit_en = 1'b1;
              lit_le = p;
            end
          end
          PH_OPEN, PH_NAME: begin
            if (st.phase == PH_OPEN && cls == CL_OPEN) begin
              // Doubled opening brace: literal text.
              lit_en = 1'b1;
              lit_le = p;
            end else begin
              if (st.phase == PH_OPEN) begin
                st_next.fname_start = p;
                st_next.conv_char   = '0;
                st_next.nested_seen = 1'b0;
                depth_n             = '0;
              end
              st_next.phase = PH_NAME;
              if (cls == CL_LBRK) depth_n = depth_n + 17'sd1;
              else if (cls == CL_RBRK) depth_n = depth_n - 17'sd1;
              st_next.bracket_depth = depth_n;
              // Terminators count only outside brackets.
              if (depth_n == 17'sd0 &&
                  (cls == CL_CLOSE || cls == CL_COLON || cls == CL_BANG)) begin
                st_next.name_stop = p;
                if (cls == CL_CLOSE) begin
                  field_en = 1'b1;
                end else if (cls == CL_COLON) begin
                  spec_en = 1'b1;
                end else if (lst) begin
                  fail_en   = 1'b1;
                  fail_code = ERR_NOCONV;
                end else begin
                  st_next.phase = PH_CONV;
                end
              end else if (lst) begin
                fail_en   = 1'b1;
                fail_code = ERR_NAME;
              end
            end
          end
          PH_CONV: begin
            st_next.conv_char = head_item.ch;
            if (lst) begin
              fail_en   = 1'b1;
              fail_code = ERR_SPEC;
            end else begin
              st_next.phase = PH_CONVX;
            end
          end
          PH_CONVX: begin
            if (cls == CL_CLOSE) begin
              field_en = 1'b1;
            end else if (cls == CL_COLON) begin
              spec_en = 1'b1;
            end else begin
              fail_en   = 1'b1;
              fail_code = ERR_COLON;
            end
          end
          PH_SPEC: begin
            if (cls == CL_OPEN) begin
              st_next.nested_seen = 1'b1;
              st_next.brace_depth = st.brace_depth + 17'd1;
            end else if (cls == CL_CLOSE) begin
              st_next.brace_depth = st.brace_depth - 17'd1;
              if (st_next.brace_depth == '0) begin
                field_en   = 1'b1;
                field_spec = 1'b1;
              end
            end
            if (!field_en && lst) begin
              fail_en   = 1'b1;
              fail_code = ERR_SPEC;
            end
          end
          default: st_next = ST_INIT;
        endcase
      end

      // Start of a format spec after the colon.
      if (spec_en) begin
        if (lst) begin
          fail_en   = 1'b1;
          fail_code = ERR_SPEC;
        end else begin
          st_next.phase       = PH_SPEC;
          st_next.fspec_start = p1;
          st_next.brace_depth = 17'd1;
          st_next.nested_seen = 1'b0;
        end
      end

      // Completed replacement field.
      if (field_en) begin
        fire                   = 1'b1;
        rec_next.literal_begin = st_next.lit_start;
        rec_next.literal_end   = st_next.lit_stop;
        rec_next.field_present = 1'b1;
        rec_next.name_begin    = st_next.fname_start;
        rec_next.name_end      = st_next.name_stop;
        rec_next.conversion    = st_next.conv_char;
        rec_next.spec_begin    = field_spec ? st_next.fspec_start : '0;
        rec_next.spec_end      = field_spec ? p : '0;
        rec_next.spec_nested   = field_spec ? st_next.nested_seen : 1'b0;
        rec_next.end_of_string = lst;
      end

      // Literal-only record.
      if (lit_en) begin
        fire                   = 1'b1;
        rec_next.literal_begin = st_next.lit_start;
        rec_next.literal_end   = lit_le;
        rec_next.end_of_string = lst;
      end

      // After a record the next literal starts past this byte.
      if (field_en || lit_en) begin
        if (lst) begin
          st_next = ST_INIT;
        end else begin
          st_next.phase     = PH_LIT;
          st_next.lit_start = p1;
        end
      end

      // A syntax or length error ends the string with an error record.
      if (fail_en) begin
        fire                   = 1'b1;
        rec_next               = '0;
        rec_next.error         = fail_code;
        rec_next.end_of_string = 1'b1;
        st_next                = ST_INIT;
        st_next.drop_rest      = !lst;
      end
    end
  end

  // Parser state and output record register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_INIT;
      rec_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (take && fire) begin
        rec_valid <= 1'b1;
        rec       <= rec_next;
      end else if (!rec_stall) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // An error record carries nothing but its code and closes the string.
  a_err_record: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.error != ERR_NONE |->
      rec.end_of_string && !rec.field_present && rec.literal_end == '0)
    else $error("error record with stray content");
  // While skipping a failed string the parser sits at the start of a string.
  a_drop_state: assert property (@(posedge clk) disable iff (rst)
    st.drop_rest |-> st.phase == PH_LIT && st.position == '0)
    else $error("skip mode with live parser state");
  // A nested spec holds at least its opening brace.
  a_nested_span: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.spec_nested |-> rec.field_present && rec.spec_end > rec.spec_begin)
    else $error("nested spec with empty span");
  // Items are only taken from a non-empty queue.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("item taken from empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/format_markup_tokenizer_core.sv @@
// Format markup tokenizer: splits brace-markup format strings into records.
//
// Input channel: byte_valid / byte_stall carry one byte of the string per item
// in byte_req, with last set on its final byte. Output channel: rec_valid /
// rec_stall carry one record per item (literal span, field name span,
// conversion, spec span, nested flag, error code, end_of_string).
// An item moves on a rising edge where valid is high and stall is low.
//
// Throughput is one byte per cycle while no stall holds the output register. A
// byte passes the classifier into a four-entry queue when it is accepted; the
// parser takes it from the queue head and registers any record it causes in
// the output register, where rec_valid rises and the record can be taken.
// Unless stalled, the parser takes one byte per cycle, one state update each.
//
// When the receiver stalls, the record waits in the output register and the
// queue keeps accepting bytes until four are waiting; then byte_stall rises.
// Reset empties the queue, clears the parser state and drops rec_valid; the
// first byte after reset starts a new string at offset zero.
//
// Depends on fmt_pkg, fmt_front, fmt_fifo and fmt_back.
`default_nettype none

module format_markup_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_req,
  input  logic        last,
  output logic        rec_valid,
  input  logic        rec_stall,
  output logic [15:0] literal_begin,
  output logic [15:0] literal_end,
  output logic        field_present,
  output logic [15:0] name_begin,
  output logic [15:0] name_end,
  output logic [7:0]  conversion,
  output logic [15:0] spec_begin,
  output logic [15:0] spec_end,
  output logic        spec_nested,
  output logic [2:0]  error,
  output logic        end_of_string
);
  import fmt_pkg::*;

  logic    q_full;
  logic    push;
  item_t   wr_item;
  logic    pop;
  logic    head_valid;
  item_t   head_item;
  record_t rec;

  // Classifier.
  fmt_front u_front (
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .wr_item    (wr_item)
  );

  // Queue between front and back.
  fmt_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (wr_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Parser and output register.
  fmt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec        (rec)
  );

  // Record fields onto their ports.
  assign literal_begin = rec.literal_begin;
  assign literal_end   = rec.literal_end;
  assign field_present = rec.field_present;
  assign name_begin    = rec.name_begin;
  assign name_end      = rec.name_end;
  assign conversion    = rec.conversion;
  assign spec_begin    = rec.spec_begin;
  assign spec_end      = rec.spec_end;
  assign spec_nested   = rec.spec_nested;
  assign error         = rec.error;
  assign end_of_string = rec.end_of_string;

endmodule

`default_nettype wire
